>>> rtl/badm_pkg.sv
// badm_pkg: constants, types and register map for the advertising data matcher
// no dependencies
package badm_pkg;

  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 64;
  localparam int unsigned PrefixW  = 48;
  localparam int unsigned MaxPrefix = 6;

  localparam logic [7:0] TypeUuid16More = 8'h02;
  localparam logic [7:0] TypeUuid16All  = 8'h03;
  localparam logic [7:0] TypeNameShort  = 8'h08;
  localparam logic [7:0] TypeNameFull   = 8'h09;

  localparam logic [15:0]        ServiceUuidRst = 16'h1812;
  localparam logic [PrefixW-1:0] NamePrefixRst  = 48'h5869_616F_5969;
  localparam logic [2:0]         PrefixLenRst   = 3'd6;
  localparam logic [2:0]         MaxPrefixLen   = 3'(MaxPrefix);

  typedef enum logic [1:0] {
    REG_SERVICE_UUID = 2'd0,
    REG_NAME_PREFIX  = 2'd1,
    REG_PREFIX_LEN   = 2'd2,
    REG_NONE         = 2'd3
  } reg_idx_t;

endpackage

>>> rtl/ble_adv_device_match_unit.sv
// ble_adv_device_match_unit: walks advertising AD structures byte by byte and
// flags a configured 16-bit service uuid and a local-name prefix
// depends on badm_pkg
//
// Usage
//  input channel: one advertising payload byte per word (in_adv_byte), with
//  in_last_byte set on the final byte of the payload. A word is taken at a
//  clock edge where in_valid is high and in_stall is low.
//  result channel: one word per payload, carrying out_uuid_seen,
//  out_name_seen and their AND on out_is_target, taken when out_valid is
//  high and out_stall is low.
//  The result of a payload is shown in the cycle after its last byte is taken.
//  Throughput is one byte per cycle while in_stall is low; the parse state is
//  updated in the same cycle a byte is taken, only the result is registered.
//  stalling: in_stall is raised only while a result is held and out_stall is
//  high, so bytes keep flowing while the result register is empty or drains.
//  reset: rst_n (synchronous, active low) clears the parse state and the
//  result register and loads uuid 0x1812, the six-character default prefix
//  and a prefix length of six. The user must write registers over APB at byte
//  addresses 0, 8 and 16 only while no payload is in flight (not enforced).
module ble_adv_device_match_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_adv_byte,
  input  logic                        in_last_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_is_target,
  output logic                        out_uuid_seen,
  output logic                        out_name_seen,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [badm_pkg::AddrW-1:0]  paddr,
  input  logic [badm_pkg::DataW-1:0]  pwdata,
  output logic [badm_pkg::DataW-1:0]  prdata,
  output logic                        pready
);
  import badm_pkg::*;

  logic [15:0]        service_uuid_r;
  logic [PrefixW-1:0] name_prefix_r;
  logic [2:0]         prefix_len_r;

  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic       awaiting_type_r, awaiting_type_nxt;
  logic [7:0] struct_type_r, struct_type_nxt;
  logic [7:0] uuid_low_r, uuid_low_nxt;
  logic       uuid_phase_r, uuid_phase_nxt;
  logic [2:0] name_pos_r, name_pos_nxt;
  logic       name_ok_r, name_ok_nxt;
  logic       uuid_flag_r, uuid_flag_nxt;
  logic       name_flag_r, name_flag_nxt;

  logic       out_valid_r;
  logic       is_target_r, uuid_seen_r, name_seen_r;

  logic       in_accept, out_accept, cfg_write;
  reg_idx_t   reg_idx;
  logic [2:0] eff_len;
  logic [7:0] want_byte;
  logic       is_name_in, is_name_cur, is_uuid_cur;

  assign pready     = 1'b1;
  assign reg_idx    = reg_idx_t'(paddr[AddrW-1:3]);
  assign cfg_write  = psel && penable && pwrite && pready;
  assign in_stall   = out_valid_r && out_stall;
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid_r && !out_stall;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      service_uuid_r <= ServiceUuidRst;
      name_prefix_r  <= NamePrefixRst;
      prefix_len_r   <= PrefixLenRst;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_SERVICE_UUID: service_uuid_r <= pwdata[15:0];
        REG_NAME_PREFIX:  name_prefix_r  <= pwdata[PrefixW-1:0];
        REG_PREFIX_LEN:   prefix_len_r   <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SERVICE_UUID: prdata = {{(DataW-16){1'b0}}, service_uuid_r};
      REG_NAME_PREFIX:  prdata = {{(DataW-PrefixW){1'b0}}, name_prefix_r};
      REG_PREFIX_LEN:   prdata = {{(DataW-3){1'b0}}, prefix_len_r};
      default:          prdata = '0;
    endcase
  end

  assign eff_len     = (prefix_len_r > MaxPrefixLen) ? MaxPrefixLen : prefix_len_r;
  assign is_name_in  = (in_adv_byte == TypeNameShort) || (in_adv_byte == TypeNameFull);
  assign is_name_cur = (struct_type_r == TypeNameShort) || (struct_type_r == TypeNameFull);
  assign is_uuid_cur = (struct_type_r == TypeUuid16More) || (struct_type_r == TypeUuid16All);

  // expected name character, first character in the top byte
  always_comb begin
    case (name_pos_r)
      3'd0:    want_byte = name_prefix_r[47:40];
      3'd1:    want_byte = name_prefix_r[39:32];
      3'd2:    want_byte = name_prefix_r[31:24];
      3'd3:    want_byte = name_prefix_r[23:16];
      3'd4:    want_byte = name_prefix_r[15:8];
      default: want_byte = name_prefix_r[7:0];
    endcase
  end

  // per-byte parse step
  always_comb begin
    bytes_left_nxt    = bytes_left_r;
    awaiting_type_nxt = awaiting_type_r;
    struct_type_nxt   = struct_type_r;
    uuid_low_nxt      = uuid_low_r;
    uuid_phase_nxt    = uuid_phase_r;
    name_pos_nxt      = name_pos_r;
    name_ok_nxt       = name_ok_r;
    uuid_flag_nxt     = uuid_flag_r;
    name_flag_nxt     = name_flag_r;
    if (awaiting_type_r) begin
      awaiting_type_nxt = 1'b0;
      struct_type_nxt   = in_adv_byte;
      bytes_left_nxt    = bytes_left_r - 8'd1;
      uuid_phase_nxt    = 1'b0;
      uuid_low_nxt      = '0;
      name_pos_nxt      = '0;
      name_ok_nxt       = 1'b1;
      if (is_name_in && (eff_len == 3'd0)) begin
        name_flag_nxt = 1'b1;
      end
    end else if (bytes_left_r == 8'd0) begin
      // zero length byte is padding
      if (in_adv_byte != 8'd0) begin
        bytes_left_nxt    = in_adv_byte;
        awaiting_type_nxt = 1'b1;
      end
    end else begin
      bytes_left_nxt = bytes_left_r - 8'd1;
      if (is_uuid_cur) begin
        if (!uuid_phase_r) begin
          uuid_low_nxt   = in_adv_byte;
          uuid_phase_nxt = 1'b1;
        end else begin
          if ({in_adv_byte, uuid_low_r} == service_uuid_r) begin
            uuid_flag_nxt = 1'b1;
          end
          uuid_phase_nxt = 1'b0;
        end
      end else if (is_name_cur) begin
        if (name_pos_r < eff_len) begin
          name_ok_nxt  = name_ok_r && (want_byte == in_adv_byte);
          name_pos_nxt = name_pos_r + 3'd1;
          if ((name_pos_nxt == eff_len) && name_ok_nxt) begin
            name_flag_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_accept && in_last_byte)) begin
      bytes_left_r    <= '0;
      awaiting_type_r <= 1'b0;
      struct_type_r   <= '0;
      uuid_low_r      <= '0;
      uuid_phase_r    <= 1'b0;
      name_pos_r      <= '0;
      name_ok_r       <= 1'b1;
      uuid_flag_r     <= 1'b0;
      name_flag_r     <= 1'b0;
    end else if (in_accept) begin
      bytes_left_r    <= bytes_left_nxt;
      awaiting_type_r <= awaiting_type_nxt;
      struct_type_r   <= struct_type_nxt;
      uuid_low_r      <= uuid_low_nxt;
      uuid_phase_r    <= uuid_phase_nxt;
      name_pos_r      <= name_pos_nxt;
      name_ok_r       <= name_ok_nxt;
      uuid_flag_r     <= uuid_flag_nxt;
      name_flag_r     <= name_flag_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept && in_last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_accept) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_last_byte) begin
      is_target_r <= uuid_flag_nxt && name_flag_nxt;
      uuid_seen_r <= uuid_flag_nxt;
      name_seen_r <= name_flag_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_is_target = is_target_r;
  assign out_uuid_seen = uuid_seen_r;
  assign out_name_seen = name_seen_r;

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_valid && !in_stall && in_last_byte))
    else $error("result raised without a last byte");

  a_target_and: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (is_target_r == (uuid_seen_r && name_seen_r)))
    else $error("target flag disagrees with its parts");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_last_byte) |=>
      (bytes_left_r == 8'd0 && !awaiting_type_r && !uuid_flag_r && !name_flag_r))
    else $error("parse state not cleared after payload");

  a_name_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    name_pos_r <= MaxPrefixLen)
    else $error("name position out of range");

endmodule

>>> test/tb.sv
// tb: self-checking testbench for ble_adv_device_match_unit, random and directed payloads
// predicts each payload verdict in a scoreboard class and compares it on the result channel
// depends on badm_pkg and the rtl of ble_adv_device_match_unit
`timescale 1ns / 1ps

module tb;
  import badm_pkg::*;

  localparam int QuietLimit = 5000;
  localparam int PhaseBytes = 170;

  typedef struct packed {
    logic is_target;
    logic uuid_seen;
    logic name_seen;
  } verdict_t;

  class verdict_board;
    logic [15:0]        uuid_want;
    logic [PrefixW-1:0] prefix_want;
    logic [2:0]         prefix_len;
    logic [7:0]         bytes_left;
    logic               awaiting_type;
    logic [7:0]         struct_type;
    logic [7:0]         uuid_lo;
    logic               uuid_odd;
    logic [2:0]         name_pos;
    logic               name_ok;
    logic               uuid_hit;
    logic               name_hit;
    verdict_t           pending_verdicts[$];
    int                 errors;

    function new();
      uuid_want   = ServiceUuidRst;
      prefix_want = NamePrefixRst;
      prefix_len  = PrefixLenRst;
      errors      = 0;
      restart();
    endfunction

    function void restart();
      bytes_left    = '0;
      awaiting_type = 1'b0;
      struct_type   = '0;
      uuid_lo       = '0;
      uuid_odd      = 1'b0;
      name_pos      = '0;
      name_ok       = 1'b1;
      uuid_hit      = 1'b0;
      name_hit      = 1'b0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [DataW-1:0] v);
      case (idx)
        REG_SERVICE_UUID: uuid_want = v[15:0];
        REG_NAME_PREFIX:  prefix_want = v[PrefixW-1:0];
        REG_PREFIX_LEN:   prefix_len = v[2:0];
        default: ;
      endcase
    endfunction

    function logic [2:0] eff_len();
      return (prefix_len > MaxPrefixLen) ? MaxPrefixLen : prefix_len;
    endfunction

    function void absorb_byte(logic [7:0] b, logic last);
      logic [2:0] plen;
      logic [7:0] want;
      verdict_t   v;
      plen = eff_len();
      if (awaiting_type) begin
        awaiting_type = 1'b0;
        struct_type   = b;
        bytes_left    = bytes_left - 8'd1;
        uuid_odd      = 1'b0;
        uuid_lo       = '0;
        name_pos      = '0;
        name_ok       = 1'b1;
        if ((b == TypeNameShort || b == TypeNameFull) && plen == 3'd0) name_hit = 1'b1;
      end else if (bytes_left == 8'd0) begin
        if (b != 8'd0) begin
          bytes_left    = b;
          awaiting_type = 1'b1;
        end
      end else begin
        bytes_left = bytes_left - 8'd1;
        if (struct_type == TypeUuid16More || struct_type == TypeUuid16All) begin
          if (!uuid_odd) begin
            uuid_lo  = b;
            uuid_odd = 1'b1;
          end else begin
            if ({b, uuid_lo} == uuid_want) uuid_hit = 1'b1;
            uuid_odd = 1'b0;
          end
        end else if (struct_type == TypeNameShort || struct_type == TypeNameFull) begin
          if (name_pos < plen) begin
            want = prefix_want[8*(5-int'(name_pos)) +: 8];
            if (want != b) name_ok = 1'b0;
            name_pos = name_pos + 3'd1;
            if (name_pos == plen && name_ok) name_hit = 1'b1;
          end
        end
      end
      if (last) begin
        v.is_target = uuid_hit & name_hit;
        v.uuid_seen = uuid_hit;
        v.name_seen = name_hit;
        pending_verdicts.push_back(v);
        restart();
      end
    endfunction

    task report(string msg);
      $display("%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_verdict(logic t, logic u, logic n);
      verdict_t v;
      if (pending_verdicts.size() == 0) begin
        report("result word with no payload pending");
      end else begin
        v = pending_verdicts.pop_front();
        if (t !== v.is_target) report($sformatf("is_target %b, want %b", t, v.is_target));
        if (u !== v.uuid_seen) report($sformatf("uuid_seen %b, want %b", u, v.uuid_seen));
        if (n !== v.name_seen) report($sformatf("name_seen %b, want %b", n, v.name_seen));
      end
    endtask
  endclass

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_adv_byte = '0;
  logic               in_last_byte = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_is_target;
  logic               out_uuid_seen;
  logic               out_name_seen;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [AddrW-1:0]   paddr = '0;
  logic [DataW-1:0]   pwdata = '0;
  logic [DataW-1:0]   prdata;
  logic               pready;

  verdict_board board;
  logic [7:0]   adv_bytes[$];
  int           sender_idle = 11;
  int           sink_idle = 11;
  int           bytes_sent = 0;
  int           quiet_cycles = 0;

  ble_adv_device_match_unit u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_adv_byte   (in_adv_byte),
    .in_last_byte  (in_last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_is_target (out_is_target),
    .out_uuid_seen (out_uuid_seen),
    .out_name_seen (out_name_seen),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < sink_idle);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (in_valid && !in_stall) board.absorb_byte(in_adv_byte, in_last_byte);
      if (out_valid && !out_stall) board.check_verdict(out_is_target, out_uuid_seen,
                                                       out_name_seen);
      if (quiet_cycles >= QuietLimit) begin
        $display("ble_adv_device_match_unit: mismatch");
        $finish;
      end
    end
  end

  task send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_adv_byte  <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task send_payload();
    foreach (adv_bytes[i]) send_byte(adv_bytes[i], i == adv_bytes.size() - 1);
  endtask

  task drain();
    in_valid <= 1'b0;
    while (board.pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task apb_write(reg_idx_t idx, logic [DataW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_reg(idx, v);
    @(posedge clk);
  endtask

  task set_all(logic [15:0] u, logic [PrefixW-1:0] p, logic [2:0] l);
    apb_write(REG_SERVICE_UUID, DataW'(u));
    apb_write(REG_NAME_PREFIX, DataW'(p));
    apb_write(REG_PREFIX_LEN, DataW'(l));
  endtask

  function void add_uuid_list();
    int         n;
    bit         odd;
    logic [15:0] u;
    n   = $urandom_range(0, 4);
    odd = ($urandom_range(0, 5) == 0);
    adv_bytes.push_back(8'(1 + 2*n + int'(odd)));
    adv_bytes.push_back($urandom_range(0, 1) ? TypeUuid16More : TypeUuid16All);
    for (int i = 0; i < n; i++) begin
      u = ($urandom_range(0, 2) == 0) ? board.uuid_want : 16'($urandom);
      adv_bytes.push_back(u[7:0]);
      adv_bytes.push_back(u[15:8]);
    end
    if (odd) adv_bytes.push_back(8'($urandom));
  endfunction

  function void add_name();
    int         m;
    int         bad;
    logic [7:0] c;
    m   = $urandom_range(0, 8);
    bad = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : -1;
    adv_bytes.push_back(8'(m + 1));
    adv_bytes.push_back($urandom_range(0, 1) ? TypeNameShort : TypeNameFull);
    for (int i = 0; i < m; i++) begin
      c = (i < 6) ? board.prefix_want[8*(5-i) +: 8] : 8'($urandom);
      if (i == bad) c = c ^ 8'(1 << $urandom_range(0, 7));
      adv_bytes.push_back(c);
    end
  endfunction

  function void add_other();
    int n;
    n = $urandom_range(1, 6);
    adv_bytes.push_back(8'(n));
    for (int i = 0; i < n; i++) adv_bytes.push_back(8'($urandom));
  endfunction

  function void make_payload();
    int k;
    int cut;
    adv_bytes.delete();
    k = $urandom_range(0, 15);
    if (k == 0) begin
      repeat ($urandom_range(1, 12)) adv_bytes.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 6))
          0, 1:    add_uuid_list();
          2, 3:    add_name();
          4, 5:    add_other();
          default: adv_bytes.push_back(8'h00);
        endcase
      end
      if (k == 1 && adv_bytes.size() > 1) begin
        cut = $urandom_range(1, adv_bytes.size() - 1);
        repeat (cut) void'(adv_bytes.pop_back());
      end
    end
  endfunction

  initial begin
    board = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed payloads against the reset settings, then one with prefix length zero
    adv_bytes = '{8'h03, 8'h03, 8'h12, 8'h18, 8'h07, 8'h09,
                  8'h58, 8'h69, 8'h61, 8'h6F, 8'h59, 8'h69};
    send_payload();
    adv_bytes = '{8'h00, 8'h01, 8'hFF, 8'h02, 8'h02, 8'h12};
    send_payload();
    adv_bytes = '{8'hFF};
    send_payload();
    adv_bytes = '{8'h04, 8'h09, 8'h58, 8'h69, 8'h61};
    send_payload();
    drain();
    apb_write(REG_PREFIX_LEN, DataW'(0));
    adv_bytes = '{8'h01, 8'h08};
    send_payload();
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_all(ServiceUuidRst, NamePrefixRst, PrefixLenRst);
        1: set_all(16'($urandom), PrefixW'({$urandom, $urandom}), 3'($urandom_range(1, 6)));
        2: set_all(16'hFFFF, '1, 3'd7);
        3: set_all(16'h0000, '0, 3'd0);
        default: set_all(16'($urandom), PrefixW'({$urandom, $urandom}),
                         3'($urandom_range(0, 7)));
      endcase
      sender_idle = (ph == 2) ? 0 : 11;
      sink_idle   = (ph == 2) ? 0 : 11;
      bytes_sent  = 0;
      while (bytes_sent < PhaseBytes) begin
        make_payload();
        send_payload();
        if ($urandom_range(0, 19) == 0) drain();
      end
      drain();
    end

    sender_idle = 11;
    sink_idle   = 11;
    repeat (10) @(posedge clk);
    if (board.errors == 0) begin
      $display("ble_adv_device_match_unit: match");
    end else begin
      $display("ble_adv_device_match_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/badm_pkg.sv
rtl/ble_adv_device_match_unit.sv
test/tb.sv
